FILE: src/button_debounce_press_classifier_assert.svh
// Assertion macros for the button debounce and press classifier RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BDPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdpc check failed");

// Next-cycle implication, disabled while reset is high.
`define BDPC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdpc check failed");

`endif

FILE: src/bdpc_pkg.sv
// Shared types and constants for the button debounce and press classifier.
// No dependencies; used by every module of the block.
`default_nettype none

package bdpc_pkg;

   localparam int unsigned TimeWidth = 32;
   localparam int unsigned CfgWidth  = 16;

   // Register reset values, in milliseconds
   localparam logic [CfgWidth-1:0] DebounceReset = 16'd15;
   localparam logic [CfgWidth-1:0] ShortMaxReset = 16'd1000;
   localparam logic [CfgWidth-1:0] LongReset     = 16'd3000;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_DEBOUNCE  = 2'd0,
      CSR_SHORT_MAX = 2'd1,
      CSR_LONG      = 2'd2
   } csr_index_type;

   // Debounced level before and after one sample
   typedef struct packed {
      logic stable_prev;
      logic stable_level;
   } level_type;

   // Events raised by one sample
   typedef struct packed {
      logic press_hit;
      logic short_hit;
      logic release_hit;
      logic long_hit;
   } event_type;

endpackage

`default_nettype wire

FILE: src/bdpc_debounce.sv
// Debounce stage: raw level tracking, settle window timing and stable level.
// Depends on bdpc_pkg.
`default_nettype none

module bdpc_debounce (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 step,
   input  wire logic                                 pin_level,
   input  wire logic [bdpc_pkg::TimeWidth-1:0]       now_ms,
   input  wire logic [bdpc_pkg::CfgWidth-1:0]        debounce_ms,
   output bdpc_pkg::level_type                       level
);

   logic                               raw_seen_ff,     raw_seen_in;
   logic                               settling_ff,     settling_in;
   logic [bdpc_pkg::TimeWidth-1:0]     settle_start_ff, settle_start_in;
   logic                               stable_ff,       stable_in;

   logic                               raw_change;
   logic                               settling_mid;
   logic [bdpc_pkg::TimeWidth-1:0]     settle_elapsed;
   logic                               settle_done;

   // A raw change restarts the window at this sample's time
   always_comb begin
      raw_change      = pin_level != raw_seen_ff;
      settling_mid    = raw_change | settling_ff;
      settle_start_in = raw_change ? now_ms : settle_start_ff;
      settle_elapsed  = now_ms - settle_start_in;
      settle_done     = settling_mid &&
                        (settle_elapsed >= {{(bdpc_pkg::TimeWidth-bdpc_pkg::CfgWidth){1'b0}},
                                            debounce_ms});
      raw_seen_in     = pin_level;
      settling_in     = settling_mid & ~settle_done;
      stable_in       = settle_done ? pin_level : stable_ff;
   end

   assign level.stable_prev  = stable_ff;
   assign level.stable_level = stable_in;

   // State advances once per transfer into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_seen_ff     <= 1'b1;
         settling_ff     <= 1'b0;
         settle_start_ff <= '0;
         stable_ff       <= 1'b1;
      end else if (step) begin
         raw_seen_ff     <= raw_seen_in;
         settling_ff     <= settling_in;
         settle_start_ff <= settle_start_in;
         stable_ff       <= stable_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/bdpc_classify.sv
// Press classifier: press/release edges, short press check, long press timer.
// Depends on bdpc_pkg.
`default_nettype none

module bdpc_classify (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 step,
   input  wire logic [bdpc_pkg::TimeWidth-1:0]       now_ms,
   input  wire bdpc_pkg::level_type                  level,
   input  wire logic [bdpc_pkg::CfgWidth-1:0]        short_max_ms,
   input  wire logic [bdpc_pkg::CfgWidth-1:0]        long_ms,
   output bdpc_pkg::event_type                       events
);

   localparam int unsigned PadWidth = bdpc_pkg::TimeWidth - bdpc_pkg::CfgWidth;

   logic                               long_pending_ff, long_pending_in;
   logic [bdpc_pkg::TimeWidth-1:0]     press_start_ff,  press_start_in;

   logic                               stable_edge;
   logic                               pending_mid;
   logic [bdpc_pkg::TimeWidth-1:0]     press_elapsed;
   logic [bdpc_pkg::TimeWidth-1:0]     hold_elapsed;

   always_comb begin
      stable_edge        = level.stable_level != level.stable_prev;
      events.press_hit   = stable_edge & ~level.stable_level;
      events.release_hit = stable_edge &  level.stable_level;
      press_elapsed      = now_ms - press_start_ff;
      events.short_hit   = events.release_hit &&
                           (press_elapsed <= {{PadWidth{1'b0}}, short_max_ms});
      // press arms the long timer, release disarms it
      pending_mid        = events.press_hit ? 1'b1 :
                           (events.release_hit ? 1'b0 : long_pending_ff);
      hold_elapsed       = events.press_hit ? '0 : press_elapsed;
      events.long_hit    = pending_mid && (hold_elapsed >= {{PadWidth{1'b0}}, long_ms});
      long_pending_in    = pending_mid & ~events.long_hit;
      press_start_in     = events.press_hit ? now_ms : press_start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_pending_ff <= 1'b0;
         press_start_ff  <= '0;
      end else if (step) begin
         long_pending_ff <= long_pending_in;
         press_start_ff  <= press_start_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/button_debounce_press_classifier.sv
// Top level of the button debounce and press classifier.
// Depends on bdpc_pkg, bdpc_debounce, bdpc_classify and the assertion header.
`default_nettype none

// Takes one button sample per cycle while rsp_tready is high and returns exactly one result per sample.
// A sample goes into an input register, is debounced and classified in one
// pass of logic, and lands in the result register, which drives rsp_tdata;
// a new sample is taken every cycle while
// rsp_tready is high. The two registers let the input side move on while a
// result waits. Timers hold across samples in the debounce and press stages;
// their state advances as each sample moves into the result register.
// Configuration writes are always taken (csr_ready is high) and apply to
// samples processed afterwards.

`include "button_debounce_press_classifier_assert.svh"

module button_debounce_press_classifier (
   input  wire logic        clock,
   input  wire logic        reset,
   // sample channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [39:0] req_tdata,   // [0] pin_level, [32:1] now_ms, [39:33] zero
   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,   // [0] stable_level, [1] press_event,
                                         // [2] short_event, [3] release_event,
                                         // [4] long_event, [7:5] zero
   // configuration writes
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);

   logic                               in_vld_ff,   in_vld_in;
   logic                               in_pin_ff;
   logic [bdpc_pkg::TimeWidth-1:0]     in_now_ff;
   logic                               out_vld_ff,  out_vld_in;
   logic [4:0]                         out_data_ff;

   logic [bdpc_pkg::CfgWidth-1:0]      debounce_ff;
   logic [bdpc_pkg::CfgWidth-1:0]      short_max_ff;
   logic [bdpc_pkg::CfgWidth-1:0]      long_ff;

   logic                               req_xfer;
   logic                               advance;
   bdpc_pkg::level_type                level;
   bdpc_pkg::event_type                events;

   // Handshake: the input register drains into the result register
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign in_vld_in  = req_xfer || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_tready);

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {3'b000, out_data_ff};
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_pin_ff <= req_tdata[0];
         in_now_ff <= req_tdata[32:1];
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= {events.long_hit, events.release_hit, events.short_hit,
                         events.press_hit, level.stable_level};
      end
   end

   // Configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= bdpc_pkg::DebounceReset;
         short_max_ff <= bdpc_pkg::ShortMaxReset;
         long_ff      <= bdpc_pkg::LongReset;
      end else if (csr_valid && csr_ready) begin
         case (bdpc_pkg::csr_index_type'(csr_addr))
            bdpc_pkg::CSR_DEBOUNCE:  debounce_ff  <= csr_wdata;
            bdpc_pkg::CSR_SHORT_MAX: short_max_ff <= csr_wdata;
            bdpc_pkg::CSR_LONG:      long_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bdpc_debounce u_debounce (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .pin_level   (in_pin_ff),
      .now_ms      (in_now_ff),
      .debounce_ms (debounce_ff),
      .level       (level)
   );

   bdpc_classify u_classify (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .now_ms       (in_now_ff),
      .level        (level),
      .short_max_ms (short_max_ff),
      .long_ms      (long_ff),
      .events       (events)
   );

   // Checks on result consistency and on the two-register pipeline
   `BDPC_ASSERT_NOW(a_press_low, clock, reset, rsp_tvalid && rsp_tdata[1], !rsp_tdata[0])
   `BDPC_ASSERT_NOW(a_release_high, clock, reset, rsp_tvalid && rsp_tdata[3], rsp_tdata[0])
   `BDPC_ASSERT_NOW(a_short_needs_release, clock, reset, rsp_tvalid && rsp_tdata[2], rsp_tdata[3])
   `BDPC_ASSERT_NOW(a_long_while_held, clock, reset, rsp_tvalid && rsp_tdata[4], !rsp_tdata[0])
   `BDPC_ASSERT_NXT(a_advance_fills_out, clock, reset, advance, out_vld_ff)
   `BDPC_ASSERT_NXT(a_stall_keeps_input, clock, reset, in_vld_ff && !advance, in_vld_ff)

endmodule

`default_nettype wire

FILE: tb/button_debounce_press_classifier_tb.sv
// Self-checking testbench for the button debounce and press classifier.
// Depends on bdpc_pkg and button_debounce_press_classifier; reads no files.
`default_nettype none

module button_debounce_press_classifier_tb;

   localparam int unsigned HalfPeriod    = 10;
   localparam int unsigned ResetCycles   = 4;
   localparam int unsigned RandomItems   = 550;
   localparam int unsigned PhaseItems    = 60;
   localparam int unsigned DrainCycles   = 8;
   localparam int unsigned TimeoutCycles = 200000;
   localparam int unsigned PrintLimit    = 40;
   localparam int unsigned DirectedRows  = 32;
   // unmapped register index; writes to it must change nothing
   localparam logic [1:0]  CsrSpare      = 2'd3;

   // one result, stable_level in bit 0 as on rsp_tdata
   typedef struct packed {
      logic long_hit;
      logic release_hit;
      logic short_hit;
      logic press_hit;
      logic stable_level;
   } sample_result_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   // directed step: a sample, or a register write (addr, value[15:0])
   typedef struct packed {
      row_kind_type      kind;
      logic              pin;
      logic [1:0]        addr;
      logic [31:0]       value;
      logic              given;   // result typed in below, else predicted
      sample_result_type want;
   } plan_row_type;

   // DUT ports
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // [0] pin_level, [32:1] now_ms, [39:33] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [0] stable_level, [1] press_event, [2] short_event,
                                   // [3] release_event, [4] long_event, [7:5] zero
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_addr   = '0;
   logic [15:0] csr_wdata  = '0;

   // predictor copy of the registers and the timing state
   logic [15:0] cfg_debounce    = bdpc_pkg::DebounceReset;
   logic [15:0] cfg_short_max   = bdpc_pkg::ShortMaxReset;
   logic [15:0] cfg_long        = bdpc_pkg::LongReset;
   logic        raw_level       = 1'b1;
   logic        settle_active   = 1'b0;
   logic [31:0] settle_from_ms  = '0;
   logic        level_now       = 1'b1;
   logic        level_before    = 1'b1;
   logic        long_armed      = 1'b0;
   logic [31:0] press_from_ms   = '0;

   sample_result_type expected_q [$];
   string             result_field [5] = '{"stable_level", "press_event", "short_event",
                                           "release_event", "long_event"};

   int unsigned error_count   = 0;
   int unsigned result_count  = 0;
   int unsigned sample_count  = 0;
   int unsigned write_count   = 0;
   int unsigned gesture_count = 0;
   int unsigned phase_count   = 0;
   bit          steady        = 1'b0;   // both sides run without gaps while set
   logic [31:0] wall_ms       = '0;

   // rows 0-12 use reset settings: debounce 15, short limit 1000, long 3000
   // want: {long, release, short, press, stable}
   plan_row_type directed_plan [DirectedRows] = '{
      '{ROW_SAMPLE, 1'b1, '0, 32'd0,    1'b1, 5'b00001},   // idle, released
      '{ROW_SAMPLE, 1'b0, '0, 32'd100,  1'b1, 5'b00001},   // raw press, window opens
      '{ROW_SAMPLE, 1'b0, '0, 32'd114,  1'b1, 5'b00001},   // one ms short of debounce
      '{ROW_SAMPLE, 1'b0, '0, 32'd115,  1'b1, 5'b00010},   // press accepted
      '{ROW_SAMPLE, 1'b1, '0, 32'd500,  1'b1, 5'b00000},
      '{ROW_SAMPLE, 1'b1, '0, 32'd515,  1'b1, 5'b01101},   // release, short press
      '{ROW_SAMPLE, 1'b0, '0, 32'd1000, 1'b1, 5'b00001},
      '{ROW_SAMPLE, 1'b0, '0, 32'd1015, 1'b1, 5'b00010},
      '{ROW_SAMPLE, 1'b0, '0, 32'd4014, 1'b1, 5'b00000},   // one ms short of long
      '{ROW_SAMPLE, 1'b0, '0, 32'd4015, 1'b1, 5'b10000},   // long press
      '{ROW_SAMPLE, 1'b0, '0, 32'd5000, 1'b1, 5'b00000},   // reported only once
      '{ROW_SAMPLE, 1'b1, '0, 32'd5000, 1'b1, 5'b00000},
      '{ROW_SAMPLE, 1'b1, '0, 32'd5015, 1'b1, 5'b01001},   // release, not short
      // contact bounce restarts the window
      '{ROW_SAMPLE, 1'b0, '0, 32'd6000, 1'b0, '0},
      '{ROW_SAMPLE, 1'b1, '0, 32'd6005, 1'b0, '0},
      '{ROW_SAMPLE, 1'b0, '0, 32'd6010, 1'b0, '0},
      '{ROW_SAMPLE, 1'b0, '0, 32'd6024, 1'b0, '0},
      // zero debounce and zero long time, then a write to the spare index
      '{ROW_WRITE,  1'b0, bdpc_pkg::CSR_DEBOUNCE,  32'd0,    1'b0, '0},
      '{ROW_WRITE,  1'b0, bdpc_pkg::CSR_LONG,      32'd0,    1'b0, '0},
      '{ROW_WRITE,  1'b0, CsrSpare,                32'hFFFF, 1'b0, '0},
      '{ROW_SAMPLE, 1'b0, '0, 32'hFFFF_FFFF,        1'b0, '0},   // press and long at once
      '{ROW_SAMPLE, 1'b1, '0, 32'h0000_0000,        1'b0, '0},   // release across the wrap
      // largest debounce and long time, zero short limit
      '{ROW_WRITE,  1'b0, bdpc_pkg::CSR_DEBOUNCE,  32'hFFFF, 1'b0, '0},
      '{ROW_WRITE,  1'b0, bdpc_pkg::CSR_SHORT_MAX, 32'd0,    1'b0, '0},
      '{ROW_WRITE,  1'b0, bdpc_pkg::CSR_LONG,      32'hFFFF, 1'b0, '0},
      '{ROW_SAMPLE, 1'b0, '0, 32'h0000_0010,        1'b0, '0},
      '{ROW_SAMPLE, 1'b0, '0, 32'h0000_000F,        1'b0, '0},   // clock runs backwards
      '{ROW_SAMPLE, 1'b1, '0, 32'h0000_000F,        1'b0, '0},
      '{ROW_SAMPLE, 1'b1, '0, 32'h0001_000E,        1'b0, '0},   // release at the long time
      // press and release in the same ms with a zero short limit
      '{ROW_WRITE,  1'b0, bdpc_pkg::CSR_DEBOUNCE,  32'd0,    1'b0, '0},
      '{ROW_SAMPLE, 1'b0, '0, 32'h0000_2000,        1'b0, '0},
      '{ROW_SAMPLE, 1'b1, '0, 32'h0000_2000,        1'b0, '0}
   };

   button_debounce_press_classifier u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #(HalfPeriod) clock = ~clock;

   // Debounce and classify one sample, advancing the predictor state
   function automatic sample_result_type classify_sample(input logic pin,
                                                         input logic [31:0] now_ms);
      sample_result_type res;
      logic [31:0]       held_ms;
      res = '0;
      if (pin != raw_level) begin
         raw_level      = pin;
         settle_active  = 1'b1;
         settle_from_ms = now_ms;
      end
      held_ms = now_ms - settle_from_ms;
      if (settle_active && held_ms >= {16'd0, cfg_debounce}) begin
         level_now     = raw_level;
         settle_active = 1'b0;
      end
      if (level_now != level_before) begin
         if (!level_now) begin
            res.press_hit = 1'b1;
            long_armed    = 1'b1;
            press_from_ms = now_ms;
         end else begin
            held_ms = now_ms - press_from_ms;
            res.short_hit   = (held_ms <= {16'd0, cfg_short_max});
            res.release_hit = 1'b1;
            long_armed      = 1'b0;
         end
         level_before = level_now;
      end
      held_ms = now_ms - press_from_ms;
      if (long_armed && held_ms >= {16'd0, cfg_long}) begin
         res.long_hit = 1'b1;
         long_armed   = 1'b0;
      end
      res.stable_level = level_now;
      return res;
   endfunction

   task automatic flag_mismatch(input string what);
      error_count++;
      if (error_count <= PrintLimit)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   // One sample transfer; tvalid stays high so a gapless next sample follows at once
   task automatic send_sample(input logic pin, input logic [31:0] now_ms,
                              input logic given, input sample_result_type want);
      int unsigned       gap;
      sample_result_type predicted;
      csr_valid <= 1'b0;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, now_ms, pin};
      do @(posedge clock); while (!req_tready);
      predicted = classify_sample(pin, now_ms);
      expected_q.push_back(given ? want : predicted);
      sample_count++;
   endtask

   // Register write, only once every result is back
   task automatic write_register(input logic [1:0] addr, input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (addr)
         bdpc_pkg::CSR_DEBOUNCE:  cfg_debounce  = value;
         bdpc_pkg::CSR_SHORT_MAX: cfg_short_max = value;
         bdpc_pkg::CSR_LONG:      cfg_long      = value;
         default: ;
      endcase
      write_count++;
   endtask

   // Hold one raw level for span_ms, sampled two to six times, last sample exactly at the end
   task automatic hold_level(input logic pin, input int unsigned span_ms);
      int unsigned steps;
      int unsigned offset;
      steps  = $urandom_range(1, 5);
      offset = 0;
      for (int unsigned i = 0; i <= steps; i++) begin
         if (i == steps)
            offset = span_ms;
         else if (i != 0)
            offset = offset + $urandom_range(0, span_ms - offset);
         send_sample(pin, wall_ms + offset, 1'b0, '0);
      end
      wall_ms = wall_ms + span_ms;
   endtask

   // Maybe bounce, press for a duration near a limit or random, maybe bounce again, release
   task automatic button_gesture();
      int target;
      int deb;
      deb = int'(cfg_debounce);
      repeat ($urandom_range(0, 3)) begin
         hold_level(1'b0, $urandom_range(0, cfg_debounce));
         hold_level(1'b1, $urandom_range(0, cfg_debounce));
      end
      case ($urandom_range(0, 4))
         0:       target = int'(cfg_short_max) + int'($urandom_range(0, 2)) - 1;
         1:       target = int'(cfg_long) + int'($urandom_range(0, 2)) - 1;
         2:       target = int'($urandom_range(0, cfg_short_max));
         default: target = int'($urandom_range(0, 2 * cfg_long + 2));
      endcase
      // press accepted exactly at the end of the first hold
      hold_level(1'b0, 32'(cfg_debounce));
      hold_level(1'b0, (target > deb) ? target - deb : 0);
      if ($urandom_range(0, 2) == 0) begin
         hold_level(1'b1, $urandom_range(0, cfg_debounce));
         hold_level(1'b0, $urandom_range(0, cfg_debounce));
      end
      hold_level(1'b1, 32'(cfg_debounce) + $urandom_range(0, 30));
      gesture_count++;
   endtask

   // Result checker
   always @(posedge clock) begin
      sample_result_type got;
      sample_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[4:0];
         result_count++;
         if (expected_q.size() == 0) begin
            flag_mismatch($sformatf("result %05b with nothing expected", got));
         end else begin
            want = expected_q.pop_front();
            for (int b = 0; b < 5; b++)
               if (got[b] !== want[b])
                  flag_mismatch($sformatf("result %0d %s: got %b, want %b",
                                          result_count, result_field[b], got[b], want[b]));
         end
      end
   end

   // Result side: random stall before each transfer
   initial begin
      int unsigned stall;
      forever begin
         stall = steady ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && !reset));
      end
   end

   // Stimulus
   initial begin
      int unsigned directed_samples;
      int unsigned phase_start;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_WRITE)
            write_register(directed_plan[i].addr, directed_plan[i].value[15:0]);
         else
            send_sample(directed_plan[i].pin, directed_plan[i].value,
                        directed_plan[i].given, directed_plan[i].want);
      end
      directed_samples = sample_count;

      // random phases, each under its own register setting
      while (sample_count - directed_samples < RandomItems) begin
         case (phase_count)
            0: begin
               write_register(bdpc_pkg::CSR_DEBOUNCE,  bdpc_pkg::DebounceReset);
               write_register(bdpc_pkg::CSR_SHORT_MAX, bdpc_pkg::ShortMaxReset);
               write_register(bdpc_pkg::CSR_LONG,      bdpc_pkg::LongReset);
            end
            1: begin
               write_register(bdpc_pkg::CSR_DEBOUNCE,  16'd0);
               write_register(bdpc_pkg::CSR_SHORT_MAX, 16'd0);
               write_register(bdpc_pkg::CSR_LONG,      16'd1);
            end
            2: begin
               write_register(bdpc_pkg::CSR_DEBOUNCE,  16'hFFFF);
               write_register(bdpc_pkg::CSR_SHORT_MAX, 16'hFFFF);
               write_register(bdpc_pkg::CSR_LONG,      16'hFFFF);
            end
            3: begin
               write_register(bdpc_pkg::CSR_DEBOUNCE,  16'd0);
               write_register(bdpc_pkg::CSR_SHORT_MAX, 16'hFFFF);
               write_register(bdpc_pkg::CSR_LONG,      16'd1);
            end
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  write_register(bdpc_pkg::CSR_DEBOUNCE,  16'($urandom()));
                  write_register(bdpc_pkg::CSR_SHORT_MAX, 16'($urandom()));
                  write_register(bdpc_pkg::CSR_LONG,      16'($urandom_range(1, 65535)));
               end else begin
                  write_register(bdpc_pkg::CSR_DEBOUNCE,  16'($urandom_range(0, 40)));
                  write_register(bdpc_pkg::CSR_SHORT_MAX, 16'($urandom_range(0, 400)));
                  write_register(bdpc_pkg::CSR_LONG,      16'($urandom_range(1, 800)));
               end
            end
         endcase
         steady  = ($urandom_range(0, 3) == 0);
         wall_ms = (phase_count % 3 == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 2000)
                                          : $urandom();
         phase_start = sample_count;
         while (sample_count - phase_start < PhaseItems) begin
            if ($urandom_range(0, 5) == 0) begin
               // noise: random levels at random timestamps
               repeat ($urandom_range(1, 4))
                  send_sample(1'($urandom_range(0, 1)), $urandom(), 1'b0, '0);
            end else begin
               button_gesture();
            end
         end
         phase_count++;
      end

      // drain
      steady = 1'b0;
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("covered %0d samples: %0d directed, %0d random in %0d gestures over %0d settings",
               sample_count, directed_samples, sample_count - directed_samples,
               gesture_count, phase_count);
      $display("%0d register writes, %0d results checked, %0d mismatches",
               write_count, result_count, error_count);
      if (error_count == 0)
         $display("button_debounce_press_classifier_tb: done, clean");
      else
         $display("button_debounce_press_classifier_tb: done, errors");
      $finish;
   end

   // Watchdog
   initial begin
      #(TimeoutCycles * 2 * HalfPeriod);
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("button_debounce_press_classifier_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
